// ===== rtl/tcf_pkg.sv =====
// tcf_pkg: shared constants, types and helper functions of the tilt filter
`default_nettype none
package tcf_pkg;

    localparam int CAL_SAMPLES  = 1000;
    localparam int CORDIC_STEPS = 16;
    localparam int ATAN_LEN     = 24;
    localparam int CORDIC_IT    = (CORDIC_STEPS < ATAN_LEN) ? CORDIC_STEPS : ATAN_LEN;
    localparam int CI_W         = $clog2(ATAN_LEN);

    localparam int CAL_CNT_W  = $clog2(CAL_SAMPLES + 1);
    localparam int CAL_SUM_W  = $clog2(CAL_SAMPLES) + 17;
    localparam int INTERVAL_W = 20;
    localparam int WEIGHT_W   = 17;
    localparam int CFG_IDX_W  = 8;
    localparam int CFG_DATA_W = 20;

    localparam int DIV_NW = 48;
    localparam int DIV_DW = 20;
    localparam int CDC_W  = 34;
    localparam int Z_W    = 26;
    localparam int RATE_W = 26;
    localparam int STEP_W = 28;

    // reciprocal is multiplied in chunks, one chunk a cycle
    localparam int DIV_CH_W = 12;
    localparam int DIV_CH_N = 4;
    localparam int DIV_MW   = DIV_CH_W * DIV_CH_N;

    localparam int QUEUE_DEPTH = 2;
    localparam int QP_W        = $clog2(QUEUE_DEPTH);
    localparam int QC_W        = $clog2(QUEUE_DEPTH + 1);

    localparam logic [WEIGHT_W-1:0]   WEIGHT_ONE       = 17'd65536;
    localparam logic [WEIGHT_W-1:0]   RST_GYRO_WEIGHT  = 17'd64225;
    localparam logic [INTERVAL_W-1:0] RST_MAX_INTERVAL = 20'd100000;
    localparam logic signed [31:0]    INV_GAIN_Q30     = 32'sd652032874;
    localparam logic signed [Z_W-1:0] DEG90_Q16        = 26'sd5898240;

    localparam logic [CFG_IDX_W-1:0] REG_GYRO_WEIGHT  = 8'd0;
    localparam logic [CFG_IDX_W-1:0] REG_MAX_INTERVAL = 8'd1;

    typedef enum logic [1:0] {
        DIV_RATE,
        DIV_CAL,
        DIV_TIME
    } t_div_sel;

    typedef enum logic [3:0] {
        S_IDLE,
        S_BIAS,
        S_RATE,
        S_CROLL,
        S_MAG,
        S_MAGR,
        S_CPITCH,
        S_STEP_MUL,
        S_STEP_DIV,
        S_BLEND_MUL,
        S_BLEND,
        S_OUT
    } t_state;

    typedef struct packed {
        logic                  kind;
        logic                  meas_ok;
        logic signed [15:0]    accel_x;
        logic signed [15:0]    accel_y;
        logic signed [15:0]    accel_z;
        logic signed [15:0]    gyro_x;
        logic signed [15:0]    gyro_y;
        logic signed [15:0]    gyro_z;
        logic [INTERVAL_W-1:0] elapsed;
    } t_cmd;

    function automatic logic [DIV_DW-1:0] div_value(input t_div_sel sel);
        logic [DIV_DW-1:0] d;
        case (sel)
            DIV_RATE: d = 20'd131;
            DIV_CAL:  d = DIV_DW'(CAL_SAMPLES);
            DIV_TIME: d = 20'd1000000;
            default:  d = 20'd1;
        endcase
        return d;
    endfunction

    // floor((2^48 - 1) / d); numerators stay below 2^47, so the estimate is at most one short
    function automatic logic [DIV_MW-1:0] div_recip(input t_div_sel sel);
        logic [DIV_MW-1:0] m;
        case (sel)
            DIV_RATE: m = DIV_MW'(((64'd1 << DIV_NW) - 64'd1) / 64'd131);
            DIV_CAL:  m = DIV_MW'(((64'd1 << DIV_NW) - 64'd1) / 64'(CAL_SAMPLES));
            DIV_TIME: m = DIV_MW'(((64'd1 << DIV_NW) - 64'd1) / 64'd1000000);
            default:  m = DIV_MW'((64'd1 << DIV_NW) - 64'd1);
        endcase
        return m;
    endfunction

    // arctangent of 2^-i in q16.16 degrees
    function automatic logic signed [Z_W-1:0] atan_deg(input logic [CI_W-1:0] i);
        logic signed [Z_W-1:0] a;
        case (i)
            5'd0:    a = 26'sd2949120;
            5'd1:    a = 26'sd1740967;
            5'd2:    a = 26'sd919879;
            5'd3:    a = 26'sd466945;
            5'd4:    a = 26'sd234379;
            5'd5:    a = 26'sd117304;
            5'd6:    a = 26'sd58666;
            5'd7:    a = 26'sd29335;
            5'd8:    a = 26'sd14668;
            5'd9:    a = 26'sd7334;
            5'd10:   a = 26'sd3667;
            5'd11:   a = 26'sd1833;
            5'd12:   a = 26'sd917;
            5'd13:   a = 26'sd458;
            5'd14:   a = 26'sd229;
            5'd15:   a = 26'sd115;
            5'd16:   a = 26'sd57;
            5'd17:   a = 26'sd29;
            5'd18:   a = 26'sd14;
            5'd19:   a = 26'sd7;
            5'd20:   a = 26'sd4;
            5'd21:   a = 26'sd2;
            5'd22:   a = 26'sd1;
            default: a = 26'sd0;
        endcase
        return a;
    endfunction

    function automatic logic signed [31:0] sat32(input logic signed [DIV_NW:0] v);
        logic signed [31:0] r;
        if (v > $signed({{(DIV_NW-31){1'b0}}, 32'h7FFFFFFF}))
            r = 32'sh7FFFFFFF;
        else if (v < $signed({{(DIV_NW-31){1'b1}}, 32'h80000000}))
            r = 32'sh80000000;
        else
            r = v[31:0];
        return r;
    endfunction

endpackage
`default_nettype wire

// ===== rtl/tcf_if.sv =====
// tcf_if: sample, result and register-write channel interfaces
`default_nettype none
interface tcf_in_if;
    logic        valid;
    logic        ready;
    logic        kind;
    logic signed [15:0] accel_x;
    logic signed [15:0] accel_y;
    logic signed [15:0] accel_z;
    logic signed [15:0] gyro_x;
    logic signed [15:0] gyro_y;
    logic signed [15:0] gyro_z;
    logic [31:0] elapsed_us;
    modport source(output valid, kind, accel_x, accel_y, accel_z, gyro_x, gyro_y, gyro_z,
                   elapsed_us, input ready);
    modport sink(input valid, kind, accel_x, accel_y, accel_z, gyro_x, gyro_y, gyro_z,
                 elapsed_us, output ready);
endinterface

interface tcf_out_if;
    logic        valid;
    logic        ready;
    logic signed [31:0] roll_deg;
    logic signed [31:0] pitch_deg;
    logic signed [25:0] rate_x;
    logic signed [25:0] rate_y;
    logic signed [25:0] rate_z;
    logic        angles_updated;
    logic        calibration_done;
    modport source(output valid, roll_deg, pitch_deg, rate_x, rate_y, rate_z,
                   angles_updated, calibration_done, input ready);
    modport sink(input valid, roll_deg, pitch_deg, rate_x, rate_y, rate_z,
                 angles_updated, calibration_done, output ready);
endinterface

interface tcf_cfg_if;
    logic        valid;
    logic        ready;
    logic [7:0]  index;
    logic [19:0] data;
    modport source(output valid, index, data, input ready);
    modport sink(input valid, index, data, output ready);
endinterface
`default_nettype wire

// ===== rtl/tcf_front.sv =====
// tcf_front: accepts samples, classifies them and queues them for the back end
`default_nettype none
module tcf_front (
    input  wire logic                             i_clk,
    input  wire logic                             i_rst_n,
    tcf_in_if.sink                                i_in,
    input  wire logic [tcf_pkg::INTERVAL_W-1:0]   i_max_interval,
    output tcf_pkg::t_cmd                         o_cmd,
    output logic                                  o_cmd_valid,
    input  wire logic                             i_cmd_pop
);
    tcf_pkg::t_cmd                  r_q [tcf_pkg::QUEUE_DEPTH];
    logic [tcf_pkg::QP_W-1:0]       r_wp;
    logic [tcf_pkg::QP_W-1:0]       r_rp;
    logic [tcf_pkg::QC_W-1:0]       r_cnt;
    tcf_pkg::t_cmd                  in_cmd;
    logic                           push;
    logic                           pop;

    assign i_in.ready = (r_cnt != tcf_pkg::QC_W'(tcf_pkg::QUEUE_DEPTH));
    assign push       = i_in.valid && i_in.ready;
    assign pop        = i_cmd_pop && (r_cnt != '0);

    always_comb begin
        in_cmd.kind    = i_in.kind;
        // a measurement with no time or too long a gap leaves the angles alone
        in_cmd.meas_ok = !i_in.kind && (i_in.elapsed_us != 32'd0)
                         && (i_in.elapsed_us <= {12'd0, i_max_interval});
        in_cmd.accel_x = i_in.accel_x;
        in_cmd.accel_y = i_in.accel_y;
        in_cmd.accel_z = i_in.accel_z;
        in_cmd.gyro_x  = i_in.gyro_x;
        in_cmd.gyro_y  = i_in.gyro_y;
        in_cmd.gyro_z  = i_in.gyro_z;
        in_cmd.elapsed = i_in.elapsed_us[tcf_pkg::INTERVAL_W-1:0];
    end

    always_ff @(posedge i_clk) begin
        if (push)
            r_q[r_wp] <= in_cmd;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= '0;
            r_rp  <= '0;
            r_cnt <= '0;
        end else begin
            if (push)
                r_wp <= (r_wp == tcf_pkg::QP_W'(tcf_pkg::QUEUE_DEPTH - 1)) ? '0 : r_wp + 1'b1;
            if (pop)
                r_rp <= (r_rp == tcf_pkg::QP_W'(tcf_pkg::QUEUE_DEPTH - 1)) ? '0 : r_rp + 1'b1;
            if (push && !pop)
                r_cnt <= r_cnt + 1'b1;
            else if (pop && !push)
                r_cnt <= r_cnt - 1'b1;
        end
    end

    assign o_cmd       = r_q[r_rp];
    assign o_cmd_valid = (r_cnt != '0);

endmodule
`default_nettype wire

// ===== rtl/tcf_div.sv =====
// tcf_div: signed division by a selected constant through a reciprocal, rounded half away from zero
`default_nettype none
module tcf_div (
    input  wire logic                              i_clk,
    input  wire logic                              i_rst_n,
    input  wire logic                              i_start,
    input  wire logic signed [tcf_pkg::DIV_NW-1:0] i_num,
    input  tcf_pkg::t_div_sel                      i_sel,
    output logic                                   o_done,
    output logic signed [tcf_pkg::DIV_NW:0]        o_quo
);
    localparam int NW    = tcf_pkg::DIV_NW;
    localparam int DW    = tcf_pkg::DIV_DW;
    localparam int MW    = tcf_pkg::DIV_MW;
    localparam int CHW   = tcf_pkg::DIV_CH_W;
    localparam int PW    = NW + MW;
    localparam int CNT_W = $clog2(tcf_pkg::DIV_CH_N + 1);
    localparam logic [CNT_W-1:0] FIX_STEP = CNT_W'(tcf_pkg::DIV_CH_N);

    logic                 r_busy;
    logic                 r_done;
    logic [CNT_W-1:0]     r_cnt;
    logic                 r_neg;
    logic [DW-1:0]        r_d;
    logic [NW-1:0]        r_n;
    logic [MW-1:0]        r_m;
    logic [PW-1:0]        r_acc;
    logic [NW-1:0]        r_quo;
    logic [DW-1:0]        start_d;
    logic [MW-1:0]        start_m;
    logic [NW-1:0]        start_abs;
    logic [NW+CHW-1:0]    part;
    logic [PW-1:0]        acc_next;
    logic [MW-1:0]        q_est;
    logic [MW+DW-1:0]     qd;
    logic [NW-1:0]        rem;
    logic                 fix;

    assign start_d   = tcf_pkg::div_value(i_sel);
    assign start_m   = tcf_pkg::div_recip(i_sel);
    assign start_abs = i_num[NW-1] ? -i_num : i_num;
    // top chunk of the reciprocal first, accumulator shifts up each cycle
    assign part      = r_n * r_m[MW-1 -: CHW];
    assign acc_next  = {r_acc[PW-CHW-1:0], {CHW{1'b0}}} + PW'(part);
    assign q_est     = r_acc[PW-1:NW];
    assign qd        = q_est * r_d;
    assign rem       = r_n - qd[NW-1:0];
    assign fix       = (rem >= {{(NW-DW){1'b0}}, r_d});

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_neg <= i_num[NW-1];
            r_d   <= start_d;
            r_m   <= start_m;
            r_acc <= '0;
            // adding half the divisor turns truncation into rounding
            r_n   <= start_abs + {{(NW-DW){1'b0}}, start_d >> 1};
        end else if (r_busy) begin
            if (r_cnt == FIX_STEP) begin
                r_quo <= NW'(q_est) + NW'(fix);
            end else begin
                r_acc <= acc_next;
                r_m   <= r_m << CHW;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= '0;
            end else if (r_busy) begin
                if (r_cnt == FIX_STEP) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end else begin
                    r_cnt <= r_cnt + 1'b1;
                end
            end
        end
    end

    assign o_done = r_done;
    assign o_quo  = r_neg ? -$signed({1'b0, r_quo}) : $signed({1'b0, r_quo});

`ifndef SYNTH
    a_no_restart: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_start |-> !r_busy)
        else $error("divider started while busy");
`endif

endmodule
`default_nettype wire

// ===== rtl/tcf_cordic.sv =====
// tcf_cordic: iterative cordic vectoring unit giving atan2 in q16.16 degrees
`default_nettype none
module tcf_cordic (
    input  wire logic                              i_clk,
    input  wire logic                              i_rst_n,
    input  wire logic                              i_start,
    input  wire logic signed [tcf_pkg::CDC_W-1:0]  i_x,
    input  wire logic signed [tcf_pkg::CDC_W-1:0]  i_y,
    output logic                                   o_done,
    output logic signed [tcf_pkg::Z_W-1:0]         o_z,
    output logic signed [tcf_pkg::CDC_W-1:0]       o_x
);
    logic                                r_busy;
    logic                                r_done;
    logic [tcf_pkg::CI_W-1:0]            r_i;
    logic signed [tcf_pkg::CDC_W-1:0]    r_x;
    logic signed [tcf_pkg::CDC_W-1:0]    r_y;
    logic signed [tcf_pkg::Z_W-1:0]      r_z;
    logic signed [tcf_pkg::CDC_W-1:0]    dx;
    logic signed [tcf_pkg::CDC_W-1:0]    dy;
    logic signed [tcf_pkg::Z_W-1:0]      at;
    logic                                zero_vec;

    assign dx       = r_y >>> r_i;
    assign dy       = r_x >>> r_i;
    assign at       = tcf_pkg::atan_deg(r_i);
    assign zero_vec = (i_x == '0) && (i_y == '0);

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_i <= '0;
            if (zero_vec) begin
                r_x <= '0;
                r_y <= '0;
                r_z <= '0;
            end else if (i_x[tcf_pkg::CDC_W-1]) begin
                // left half plane: quarter turn first
                if (!i_y[tcf_pkg::CDC_W-1]) begin
                    r_x <= i_y;
                    r_y <= -i_x;
                    r_z <= tcf_pkg::DEG90_Q16;
                end else begin
                    r_x <= -i_y;
                    r_y <= i_x;
                    r_z <= -tcf_pkg::DEG90_Q16;
                end
            end else begin
                r_x <= i_x;
                r_y <= i_y;
                r_z <= '0;
            end
        end else if (r_busy) begin
            r_i <= r_i + 1'b1;
            if (!r_y[tcf_pkg::CDC_W-1]) begin
                r_x <= r_x + dx;
                r_y <= r_y - dy;
                r_z <= r_z + at;
            end else begin
                r_x <= r_x - dx;
                r_y <= r_y + dy;
                r_z <= r_z - at;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= !zero_vec;
                r_done <= zero_vec;
            end else if (r_busy && (r_i == tcf_pkg::CI_W'(tcf_pkg::CORDIC_IT - 1))) begin
                r_busy <= 1'b0;
                r_done <= 1'b1;
            end
        end
    end

    assign o_done = r_done;
    assign o_z    = r_z;
    assign o_x    = r_x;

endmodule
`default_nettype wire

// ===== rtl/tcf_back.sv =====
// tcf_back: sequencer that calibrates, derives rates and blends the tilt angles
`default_nettype none
module tcf_back (
    input  wire logic                           i_clk,
    input  wire logic                           i_rst_n,
    input  tcf_pkg::t_cmd                       i_cmd,
    input  wire logic                           i_cmd_valid,
    output logic                                o_cmd_pop,
    input  wire logic [tcf_pkg::WEIGHT_W-1:0]   i_gyro_weight,
    tcf_out_if.source                           o_out
);
    localparam int SW = tcf_pkg::CAL_SUM_W;
    localparam int CW = tcf_pkg::CDC_W;
    localparam int NW = tcf_pkg::DIV_NW;

    tcf_pkg::t_state r_state, n_state;
    tcf_pkg::t_cmd   r_cmd, n_cmd;
    logic [1:0]      r_ax, n_ax;
    logic            r_issued, n_issued;
    logic            r_cal_done, n_cal_done;
    logic [tcf_pkg::CAL_CNT_W-1:0] r_cal_cnt, n_cal_cnt;
    logic signed [SW-1:0]  r_sum [3];
    logic signed [SW-1:0]  n_sum [3];
    logic signed [31:0]    r_bias [3];
    logic signed [31:0]    n_bias [3];
    logic signed [tcf_pkg::RATE_W-1:0] r_rate [3];
    logic signed [tcf_pkg::RATE_W-1:0] n_rate [3];
    logic signed [tcf_pkg::Z_W-1:0]    r_acc [2];
    logic signed [tcf_pkg::Z_W-1:0]    n_acc [2];
    logic signed [31:0]    r_roll, n_roll, r_pitch, n_pitch;
    logic signed [CW-1:0]  r_xf, n_xf, r_mag, n_mag;
    logic signed [63:0]    r_prod, n_prod;
    logic signed [tcf_pkg::STEP_W-1:0] r_step, n_step;
    logic signed [51:0]    r_pg, n_pg;
    logic signed [43:0]    r_pa, n_pa;

    logic                  r_out_valid, n_out_valid;
    logic signed [31:0]    r_o_roll, n_o_roll, r_o_pitch, n_o_pitch;
    logic signed [tcf_pkg::RATE_W-1:0] r_o_rx, n_o_rx, r_o_ry, n_o_ry, r_o_rz, n_o_rz;
    logic                  r_o_upd, n_o_upd, r_o_cal, n_o_cal;

    // datapath helpers
    logic signed [15:0]    g_sel;
    logic signed [15:0]    gin [3];
    logic signed [NW-1:0]  rate_num;
    logic signed [NW-1:0]  bias_num;
    logic signed [NW-1:0]  div_num;
    tcf_pkg::t_div_sel     div_sel;
    logic                  div_start;
    logic                  div_done;
    logic signed [NW:0]    div_quo;
    logic                  cdc_start;
    logic                  cdc_done;
    logic signed [CW-1:0]  cdc_x;
    logic signed [CW-1:0]  cdc_y;
    logic signed [tcf_pkg::Z_W-1:0] cdc_z;
    logic signed [CW-1:0]  cdc_xo;
    logic signed [65:0]    mag_prod;
    logic signed [63:0]    mag_sum;
    logic signed [46:0]    step_prod;
    logic signed [31:0]    ang_sel;
    logic signed [CW-1:0]  gyro_part;
    logic [tcf_pkg::WEIGHT_W-1:0] w_eff;
    logic [tcf_pkg::WEIGHT_W-1:0] w_acc;
    logic signed [51:0]    pg_prod;
    logic signed [43:0]    pa_prod;
    logic signed [52:0]    blend_sum;
    logic [52:0]           blend_abs;
    logic [52:0]           blend_rnd;
    logic signed [NW:0]    blend_val;
    logic [tcf_pkg::CAL_CNT_W-1:0] cnt_inc;

    assign g_sel = (r_ax == 2'd0) ? r_cmd.gyro_x :
                   (r_ax == 2'd1) ? r_cmd.gyro_y : r_cmd.gyro_z;
    assign gin[0] = i_cmd.gyro_x;
    assign gin[1] = i_cmd.gyro_y;
    assign gin[2] = i_cmd.gyro_z;

    assign rate_num = $signed({{(NW-32){g_sel[15]}}, g_sel, 16'h0000})
                      - $signed({{(NW-32){r_bias[r_ax][31]}}, r_bias[r_ax]});
    assign bias_num = $signed({{(NW-SW-16){r_sum[r_ax][SW-1]}}, r_sum[r_ax], 16'h0000});

    assign mag_prod  = r_xf * tcf_pkg::INV_GAIN_Q30;
    assign mag_sum   = r_prod + 64'sd536870912;
    assign step_prod = r_rate[r_ax] * $signed({1'b0, r_cmd.elapsed});

    assign ang_sel   = r_ax[0] ? r_pitch : r_roll;
    assign gyro_part = $signed({{(CW-32){ang_sel[31]}}, ang_sel})
                       + $signed({{(CW-tcf_pkg::STEP_W){r_step[tcf_pkg::STEP_W-1]}}, r_step});
    assign w_eff     = (i_gyro_weight > tcf_pkg::WEIGHT_ONE) ? tcf_pkg::WEIGHT_ONE
                                                             : i_gyro_weight;
    assign w_acc     = tcf_pkg::WEIGHT_ONE - w_eff;
    assign pg_prod   = $signed({1'b0, w_eff}) * gyro_part;
    assign pa_prod   = $signed({1'b0, w_acc}) * r_acc[r_ax[0]];
    assign blend_sum = $signed({r_pg[51], r_pg}) + $signed({{9{r_pa[43]}}, r_pa});
    assign blend_abs = blend_sum[52] ? 53'(-blend_sum) : 53'(blend_sum);
    assign blend_rnd = (blend_abs + 53'd32768) >> 16;
    assign blend_val = blend_sum[52] ? -$signed({1'b0, blend_rnd[47:0]})
                                     : $signed({1'b0, blend_rnd[47:0]});

    assign cnt_inc = r_cal_cnt + 1'b1;

    tcf_div u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (div_start),
        .i_num   (div_num),
        .i_sel   (div_sel),
        .o_done  (div_done),
        .o_quo   (div_quo)
    );

    tcf_cordic u_cordic (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (cdc_start),
        .i_x     (cdc_x),
        .i_y     (cdc_y),
        .o_done  (cdc_done),
        .o_z     (cdc_z),
        .o_x     (cdc_xo)
    );

    always_comb begin
        n_state     = r_state;
        n_cmd       = r_cmd;
        n_ax        = r_ax;
        n_issued    = r_issued;
        n_cal_done  = r_cal_done;
        n_cal_cnt   = r_cal_cnt;
        n_sum       = r_sum;
        n_bias      = r_bias;
        n_rate      = r_rate;
        n_acc       = r_acc;
        n_roll      = r_roll;
        n_pitch     = r_pitch;
        n_xf        = r_xf;
        n_mag       = r_mag;
        n_prod      = r_prod;
        n_step      = r_step;
        n_pg        = r_pg;
        n_pa        = r_pa;
        n_out_valid = r_out_valid && !o_out.ready;
        n_o_roll    = r_o_roll;
        n_o_pitch   = r_o_pitch;
        n_o_rx      = r_o_rx;
        n_o_ry      = r_o_ry;
        n_o_rz      = r_o_rz;
        n_o_upd     = r_o_upd;
        n_o_cal     = r_o_cal;
        o_cmd_pop   = 1'b0;
        div_start   = 1'b0;
        div_num     = rate_num;
        div_sel     = tcf_pkg::DIV_RATE;
        cdc_start   = 1'b0;
        cdc_x       = {{4{r_cmd.accel_z[15]}}, r_cmd.accel_z, 14'd0};
        cdc_y       = {{4{r_cmd.accel_y[15]}}, r_cmd.accel_y, 14'd0};

        case (r_state)
            tcf_pkg::S_IDLE: begin
                if (i_cmd_valid) begin
                    o_cmd_pop  = 1'b1;
                    n_cmd      = i_cmd;
                    n_ax       = 2'd0;
                    n_issued   = 1'b0;
                    n_cal_done = 1'b0;
                    n_state    = tcf_pkg::S_RATE;
                    if (i_cmd.kind) begin
                        for (int k = 0; k < 3; k++)
                            n_sum[k] = r_sum[k] + SW'(gin[k]);
                        if (cnt_inc == tcf_pkg::CAL_CNT_W'(tcf_pkg::CAL_SAMPLES)) begin
                            n_cal_cnt = '0;
                            n_state   = tcf_pkg::S_BIAS;
                        end else begin
                            n_cal_cnt = cnt_inc;
                        end
                    end
                end
            end
            tcf_pkg::S_BIAS: begin
                div_num = bias_num;
                div_sel = tcf_pkg::DIV_CAL;
                if (!r_issued) begin
                    div_start = 1'b1;
                    n_issued  = 1'b1;
                end else if (div_done) begin
                    n_bias[r_ax] = tcf_pkg::sat32(div_quo);
                    n_issued     = 1'b0;
                    if (r_ax == 2'd2) begin
                        n_ax       = 2'd0;
                        n_roll     = '0;
                        n_pitch    = '0;
                        n_sum[0]   = '0;
                        n_sum[1]   = '0;
                        n_sum[2]   = '0;
                        n_cal_done = 1'b1;
                        n_state    = tcf_pkg::S_RATE;
                    end else begin
                        n_ax = r_ax + 1'b1;
                    end
                end
            end
            tcf_pkg::S_RATE: begin
                if (!r_issued) begin
                    div_start = 1'b1;
                    n_issued  = 1'b1;
                end else if (div_done) begin
                    n_rate[r_ax] = div_quo[tcf_pkg::RATE_W-1:0];
                    n_issued     = 1'b0;
                    if (r_ax == 2'd2) begin
                        n_ax    = 2'd0;
                        n_state = r_cmd.meas_ok ? tcf_pkg::S_CROLL : tcf_pkg::S_OUT;
                    end else begin
                        n_ax = r_ax + 1'b1;
                    end
                end
            end
            tcf_pkg::S_CROLL: begin
                if (!r_issued) begin
                    cdc_start = 1'b1;
                    n_issued  = 1'b1;
                end else if (cdc_done) begin
                    n_acc[0] = cdc_z;
                    n_xf     = cdc_xo;
                    n_issued = 1'b0;
                    n_state  = tcf_pkg::S_MAG;
                end
            end
            tcf_pkg::S_MAG: begin
                n_prod  = mag_prod[63:0];
                n_state = tcf_pkg::S_MAGR;
            end
            tcf_pkg::S_MAGR: begin
                n_mag   = mag_sum[63:30];
                n_state = tcf_pkg::S_CPITCH;
            end
            tcf_pkg::S_CPITCH: begin
                cdc_x = r_mag;
                cdc_y = -$signed({{4{r_cmd.accel_x[15]}}, r_cmd.accel_x, 14'd0});
                if (!r_issued) begin
                    cdc_start = 1'b1;
                    n_issued  = 1'b1;
                end else if (cdc_done) begin
                    n_acc[1] = cdc_z;
                    n_issued = 1'b0;
                    n_ax     = 2'd0;
                    n_state  = tcf_pkg::S_STEP_MUL;
                end
            end
            tcf_pkg::S_STEP_MUL: begin
                n_prod  = {{17{step_prod[46]}}, step_prod};
                n_state = tcf_pkg::S_STEP_DIV;
            end
            tcf_pkg::S_STEP_DIV: begin
                div_num = r_prod[NW-1:0];
                div_sel = tcf_pkg::DIV_TIME;
                if (!r_issued) begin
                    div_start = 1'b1;
                    n_issued  = 1'b1;
                end else if (div_done) begin
                    n_step   = div_quo[tcf_pkg::STEP_W-1:0];
                    n_issued = 1'b0;
                    n_state  = tcf_pkg::S_BLEND_MUL;
                end
            end
            tcf_pkg::S_BLEND_MUL: begin
                n_pg    = pg_prod;
                n_pa    = pa_prod;
                n_state = tcf_pkg::S_BLEND;
            end
            tcf_pkg::S_BLEND: begin
                if (r_ax[0]) begin
                    n_pitch = tcf_pkg::sat32(blend_val);
                    n_state = tcf_pkg::S_OUT;
                end else begin
                    n_roll  = tcf_pkg::sat32(blend_val);
                    n_ax    = 2'd1;
                    n_state = tcf_pkg::S_STEP_MUL;
                end
            end
            tcf_pkg::S_OUT: begin
                // result register frees when the previous beat is taken
                if (!r_out_valid || o_out.ready) begin
                    n_out_valid = 1'b1;
                    n_o_roll    = r_roll;
                    n_o_pitch   = r_pitch;
                    n_o_rx      = r_rate[0];
                    n_o_ry      = r_rate[1];
                    n_o_rz      = r_rate[2];
                    n_o_upd     = r_cmd.meas_ok;
                    n_o_cal     = r_cal_done;
                    n_state     = tcf_pkg::S_IDLE;
                end
            end
            default: begin
                n_state = tcf_pkg::S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= tcf_pkg::S_IDLE;
            r_issued    <= 1'b0;
            r_out_valid <= 1'b0;
            r_cal_cnt   <= '0;
            r_roll      <= '0;
            r_pitch     <= '0;
            for (int k = 0; k < 3; k++) begin
                r_sum[k]  <= '0;
                r_bias[k] <= '0;
            end
        end else begin
            r_state     <= n_state;
            r_issued    <= n_issued;
            r_out_valid <= n_out_valid;
            r_cal_cnt   <= n_cal_cnt;
            r_roll      <= n_roll;
            r_pitch     <= n_pitch;
            r_sum       <= n_sum;
            r_bias      <= n_bias;
        end
    end

    always_ff @(posedge i_clk) begin
        r_cmd      <= n_cmd;
        r_ax       <= n_ax;
        r_cal_done <= n_cal_done;
        r_rate     <= n_rate;
        r_acc      <= n_acc;
        r_xf       <= n_xf;
        r_mag      <= n_mag;
        r_prod     <= n_prod;
        r_step     <= n_step;
        r_pg       <= n_pg;
        r_pa       <= n_pa;
        r_o_roll   <= n_o_roll;
        r_o_pitch  <= n_o_pitch;
        r_o_rx     <= n_o_rx;
        r_o_ry     <= n_o_ry;
        r_o_rz     <= n_o_rz;
        r_o_upd    <= n_o_upd;
        r_o_cal    <= n_o_cal;
    end

    assign o_out.valid            = r_out_valid;
    assign o_out.roll_deg         = r_o_roll;
    assign o_out.pitch_deg        = r_o_pitch;
    assign o_out.rate_x           = r_o_rx;
    assign o_out.rate_y           = r_o_ry;
    assign o_out.rate_z           = r_o_rz;
    assign o_out.angles_updated   = r_o_upd;
    assign o_out.calibration_done = r_o_cal;

`ifndef SYNTH
    a_cal_cnt_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_cal_cnt < tcf_pkg::CAL_CNT_W'(tcf_pkg::CAL_SAMPLES))
        else $error("calibration count past run length");
    a_flags_exclusive: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_valid |-> !(r_o_upd && r_o_cal))
        else $error("measurement and calibration flags both set");
    a_cordic_phase: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        cdc_start |-> (r_state == tcf_pkg::S_CROLL || r_state == tcf_pkg::S_CPITCH))
        else $error("cordic started outside an angle phase");
`endif

endmodule
`default_nettype wire

// ===== rtl/tilt_complementary_filter.sv =====
// tilt_complementary_filter: top level with register file, front end and sequencer
//
// Samples enter on i_in (valid/ready); each accepted beat gives exactly one result
// beat on o_out in the same order. Registers are written on i_cfg (index 0 gyro
// weight, index 1 largest interval in microseconds), which is always ready;
// other indexes are ignored. Write registers only while no sample is in flight.
// A two-entry queue sits between the input and the sequencer, so while a result
// waits up to three samples are taken: one in the sequencer and two queued.
// Latency is set by the shared reciprocal divider and the iterative cordic.
// Work done for each accepted sample:
//   plain calibration or rejected measurement: three rates
//   calibration completing a run: three biases, three rates
//   accepted measurement: three rates, two cordic passes,
//   two time-step divisions, two blends
// One sample is processed at a time. Reset clears angles, biases, calibration
// sums and count, and loads weight 64225 and interval limit 100000.
// A stalled receiver holds the result register; the sequencer finishes the next
// sample and waits for the register to free up.
`default_nettype none
module tilt_complementary_filter (
    input  wire logic i_clk,
    input  wire logic i_rst_n,
    tcf_in_if.sink    i_in,
    tcf_out_if.source o_out,
    tcf_cfg_if.sink   i_cfg
);
    logic [tcf_pkg::WEIGHT_W-1:0]   r_gyro_weight, n_gyro_weight;
    logic [tcf_pkg::INTERVAL_W-1:0] r_max_interval, n_max_interval;
    tcf_pkg::t_cmd                  cmd;
    logic                           cmd_valid;
    logic                           cmd_pop;

    assign i_cfg.ready = 1'b1;

    always_comb begin
        n_gyro_weight  = r_gyro_weight;
        n_max_interval = r_max_interval;
        if (i_cfg.valid) begin
            case (i_cfg.index)
                tcf_pkg::REG_GYRO_WEIGHT:  n_gyro_weight  = i_cfg.data[tcf_pkg::WEIGHT_W-1:0];
                tcf_pkg::REG_MAX_INTERVAL: n_max_interval = i_cfg.data;
                default: ;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_gyro_weight  <= tcf_pkg::RST_GYRO_WEIGHT;
            r_max_interval <= tcf_pkg::RST_MAX_INTERVAL;
        end else begin
            r_gyro_weight  <= n_gyro_weight;
            r_max_interval <= n_max_interval;
        end
    end

    tcf_front u_front (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_in           (i_in),
        .i_max_interval (r_max_interval),
        .o_cmd          (cmd),
        .o_cmd_valid    (cmd_valid),
        .i_cmd_pop      (cmd_pop)
    );

    tcf_back u_back (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cmd         (cmd),
        .i_cmd_valid   (cmd_valid),
        .o_cmd_pop     (cmd_pop),
        .i_gyro_weight (r_gyro_weight),
        .o_out         (o_out)
    );

endmodule
`default_nettype wire
